[src/utf8_lenient_decoder_macros.svh]
// Assertion macros for the lenient UTF-8 decoder.
// Expects clk and rst_n in the scope of the module that includes it.
`ifndef UTF8_LENIENT_DECODER_MACROS_SVH
`define UTF8_LENIENT_DECODER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define U8LD_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("utf8 decoder: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define U8LD_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("utf8 decoder: next-cycle check failed");

`endif

[src/utf8ld_pkg.sv]
// Types, byte constants and helper functions for the lenient UTF-8 decoder.
// No dependencies; imported by utf8_lenient_decoder.
`timescale 1ns / 1ps

package utf8ld_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_byte;
    } text_item_t;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        unit_valid;
        logic        end_of_text;
    } char_item_t;

    localparam logic [7:0] NUL_BYTE  = 8'h00;
    localparam logic [7:0] TAB_BYTE  = 8'h09;
    localparam logic [7:0] LF_BYTE   = 8'h0A;
    localparam logic [7:0] CR_BYTE   = 8'h0D;
    localparam logic [7:0] SPACE_LO  = 8'h20;
    localparam logic [7:0] PUNCT1_HI = 8'h2F;
    localparam logic [7:0] PUNCT2_LO = 8'h3A;
    localparam logic [7:0] PUNCT2_HI = 8'h3F;
    localparam logic [7:0] BRACE_LO  = 8'h7B;
    localparam logic [7:0] BRACE_HI  = 8'h7D;
    localparam logic [7:0] ASCII_END = 8'h80;

    localparam logic [7:0] CONT_LO   = 8'h80;
    localparam logic [7:0] CONT_HI   = 8'hBF;
    localparam logic [7:0] LEAD2_LO  = 8'hC2;
    localparam logic [7:0] LEAD2_HI  = 8'hDF;
    localparam logic [7:0] LEAD3_LO  = 8'hE0;
    localparam logic [7:0] LEAD3_HI  = 8'hEF;
    localparam logic [7:0] LEAD4_LO  = 8'hF0;
    localparam logic [7:0] LEAD4_HI  = 8'hF7;
    localparam logic [7:0] LEAD5_LO  = 8'hF8;
    localparam logic [7:0] LEAD5_HI  = 8'hFB;
    localparam logic [7:0] LEAD6_LO  = 8'hFC;
    localparam logic [7:0] LEAD6_HI  = 8'hFD;

    // minimum second byte after the shortest-form leads
    localparam logic [7:0] MIN2_LEAD3 = 8'hA0;
    localparam logic [7:0] MIN2_LEAD4 = 8'h90;
    localparam logic [7:0] MIN2_LEAD5 = 8'h88;
    localparam logic [7:0] MIN2_LEAD6 = 8'h84;

    localparam logic [30:0] BOM_POINT = 31'h0000FEFF;
    localparam logic [30:0] DEL_POINT = 31'h0000007F;
    localparam logic [30:0] CTRL_END  = 31'h00000020;
    localparam logic [30:0] TAB_POINT = 31'h00000009;
    localparam logic [30:0] LF_POINT  = 31'h0000000A;
    localparam logic [30:0] CR_POINT  = 31'h0000000D;

    // true when a decoded point survives the drop filter
    function automatic logic keep_point(input logic [30:0] cp);
        logic drop;
        drop = (cp == BOM_POINT) || (cp == DEL_POINT) ||
               ((cp < CTRL_END) && (cp != TAB_POINT) && (cp != LF_POINT) &&
                (cp != CR_POINT));
        return !drop;
    endfunction

    // bytes that, after a bad 2-byte lead, are decoded again
    function automatic logic retry_byte(input logic [7:0] b);
        return (b == NUL_BYTE) || (b == TAB_BYTE) || (b == LF_BYTE) ||
               (b inside {[SPACE_LO:PUNCT1_HI], [PUNCT2_LO:PUNCT2_HI],
                          [BRACE_LO:BRACE_HI]});
    endfunction

endpackage

[src/utf8_lenient_decoder.sv]
// Lenient UTF-8 decoder top level: byte items in, 16-bit code unit items out.
// Depends on utf8ld_pkg and utf8_lenient_decoder_macros.svh.
`timescale 1ns / 1ps
`include "utf8_lenient_decoder_macros.svh"
//
//  channel  | valid       | stall       | payload
//  ---------+-------------+-------------+-----------------------------------------------
//  text     | text_valid  | text_stall  | text_item (in_byte, last_byte)
//  char     | char_valid  | char_stall  | char_item (code_unit, unit_valid, end_of_text)
//
//  One byte per clock while char_stall is low; each byte passes the input
//  register, then is decoded into the result register.
//  The decode state updates when the input register hands its item on.
//  text_stall rises only when the input register is full and the result
//  register is held by char_stall; reset clears both valids and all decode state.
//  A byte that yields nothing and is not last produces no char item.

module utf8_lenient_decoder
    import utf8ld_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       text_valid,
    output logic       text_stall,
    input  text_item_t text_item,
    output logic       char_valid,
    input  logic       char_stall,
    output char_item_t char_item
);

    // pipeline registers
    logic       s1_valid_reg, s1_valid_next;
    text_item_t s1_item_reg;
    logic       char_valid_reg, char_valid_next;
    char_item_t char_item_reg, char_item_next;

    // decode state
    logic [2:0]  exp_len_reg, exp_len_next;   // 0 = no sequence open
    logic [2:0]  seen_reg, seen_next;
    logic [30:0] partial_reg, partial_next;
    logic [7:0]  min2_reg, min2_next;
    logic        nul_reg, nul_next;

    logic        advance;
    logic        consume;
    logic        text_take;
    logic [7:0]  b;

    logic [2:0]  lead_len;
    logic [30:0] lead_val;
    logic [7:0]  lead_min;

    logic        use_lead;
    logic        have;
    logic [30:0] cp;
    logic [30:0] part;
    logic [7:0]  lo;

    assign advance    = !char_valid_reg || !char_stall;
    assign consume    = s1_valid_reg && advance;
    assign text_stall = s1_valid_reg && !advance;
    assign text_take  = text_valid && !text_stall;
    assign char_valid = char_valid_reg;
    assign char_item  = char_item_reg;
    assign b          = s1_item_reg.in_byte;

    // lead byte classification: length, payload bits, overlong guard
    always_comb
    begin
        lead_len = 3'd0;
        lead_val = '0;
        lead_min = CONT_LO;
        case (b) inside
            [LEAD2_LO:LEAD2_HI]:
            begin
                lead_len = 3'd2;
                lead_val = {26'd0, b[4:0]};
            end
            [LEAD3_LO:LEAD3_HI]:
            begin
                lead_len = 3'd3;
                lead_val = {27'd0, b[3:0]};
                lead_min = (b == LEAD3_LO) ? MIN2_LEAD3 : CONT_LO;
            end
            [LEAD4_LO:LEAD4_HI]:
            begin
                lead_len = 3'd4;
                lead_val = {28'd0, b[2:0]};
                lead_min = (b == LEAD4_LO) ? MIN2_LEAD4 : CONT_LO;
            end
            [LEAD5_LO:LEAD5_HI]:
            begin
                lead_len = 3'd5;
                lead_val = {29'd0, b[1:0]};
                lead_min = (b == LEAD5_LO) ? MIN2_LEAD5 : CONT_LO;
            end
            [LEAD6_LO:LEAD6_HI]:
            begin
                lead_len = 3'd6;
                lead_val = {30'd0, b[0]};
                lead_min = (b == LEAD6_LO) ? MIN2_LEAD6 : CONT_LO;
            end
            default:
            begin
                lead_len = 3'd0;
            end
        endcase
    end

    // one byte of decode against the current state
    always_comb
    begin
        exp_len_next = exp_len_reg;
        seen_next    = seen_reg;
        partial_next = partial_reg;
        min2_next    = min2_reg;
        nul_next     = nul_reg;
        use_lead     = 1'b0;
        have         = 1'b0;
        cp           = '0;
        part         = {partial_reg[24:0], b[5:0]};
        lo           = (seen_reg == 3'd1) ? min2_reg : CONT_LO;

        if (nul_reg)
        begin
            // text already ended by NUL: ignore bytes until the last one
            use_lead = 1'b0;
        end
        else if (exp_len_reg == 3'd0)
        begin
            use_lead = 1'b1;
        end
        else if ((b >= lo) && (b <= CONT_HI))
        begin
            if ((seen_reg + 3'd1) >= exp_len_reg)
            begin
                exp_len_next = 3'd0;
                seen_next    = 3'd0;
                partial_next = '0;
                min2_next    = CONT_LO;
                cp           = part;
                have         = keep_point(part);
            end
            else
            begin
                partial_next = part;
                seen_next    = seen_reg + 3'd1;
            end
        end
        else
        begin
            // broken sequence: drop what was gathered
            exp_len_next = 3'd0;
            seen_next    = 3'd0;
            partial_next = '0;
            min2_next    = CONT_LO;
            use_lead     = (exp_len_reg == 3'd2) ? retry_byte(b) : 1'b1;
        end

        if (use_lead)
        begin
            if (b == NUL_BYTE)
            begin
                nul_next = 1'b1;
            end
            else if (b < ASCII_END)
            begin
                cp   = {23'd0, b};
                have = keep_point(cp);
            end
            else if (lead_len != 3'd0)
            begin
                exp_len_next = lead_len;
                seen_next    = 3'd1;
                partial_next = lead_val;
                min2_next    = lead_min;
            end
        end

        if (s1_item_reg.last_byte)
        begin
            exp_len_next = 3'd0;
            seen_next    = 3'd0;
            partial_next = '0;
            min2_next    = CONT_LO;
            nul_next     = 1'b0;
        end

        char_item_next.code_unit   = have ? cp[15:0] : 16'd0;
        char_item_next.unit_valid  = have;
        char_item_next.end_of_text = s1_item_reg.last_byte;
    end

    always_comb
    begin
        if (text_take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
        if (advance)
        begin
            char_valid_next = consume && (have || s1_item_reg.last_byte);
        end
        else
        begin
            char_valid_next = char_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            char_valid_reg <= 1'b0;
            exp_len_reg    <= 3'd0;
            seen_reg       <= 3'd0;
            partial_reg    <= '0;
            min2_reg       <= CONT_LO;
            nul_reg        <= 1'b0;
        end
        else
        begin
            s1_valid_reg   <= s1_valid_next;
            char_valid_reg <= char_valid_next;
            if (consume)
            begin
                exp_len_reg <= exp_len_next;
                seen_reg    <= seen_next;
                partial_reg <= partial_next;
                min2_reg    <= min2_next;
                nul_reg     <= nul_next;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (text_take)
        begin
            s1_item_reg <= text_item;
        end
        if (consume)
        begin
            char_item_reg <= char_item_next;
        end
    end

    // a NUL-ended text never leaves a sequence open
    `U8LD_ASSERT_IMP(a_nul_closed, nul_reg, exp_len_reg == 3'd0)
    // byte count stays inside the open sequence
    `U8LD_ASSERT_IMP(a_seen_range, exp_len_reg != 3'd0,
                     (seen_reg != 3'd0) && (seen_reg < exp_len_reg))
    // an item without a character only ever marks the end of the text
    `U8LD_ASSERT_IMP(a_empty_is_end, char_valid && !char_item.unit_valid,
                     char_item.end_of_text && (char_item.code_unit == 16'd0))
    // a last byte handed on leaves the decoder fully cleared
    `U8LD_ASSERT_NXT(a_last_clears, consume && s1_item_reg.last_byte,
                     (exp_len_reg == 3'd0) && !nul_reg)

endmodule

[sim/utf8ld_tb_pkg.sv]
// Scoreboard for the lenient UTF-8 decoder bench: byte-level decode predictor
// plus the queue of expected char items. Depends on utf8ld_pkg.
`timescale 1ns / 1ps

package utf8ld_tb_pkg;
    import utf8ld_pkg::*;

    class char_scoreboard;
        char_item_t  expected_chars[$];
        int unsigned mismatches;
        int unsigned bytes_noted;
        int unsigned chars_checked;

        // decoder state
        bit [2:0]  seq_len;
        bit [2:0]  seq_seen;
        bit [30:0] seq_value;
        bit [7:0]  seq_min2;
        bit        nul_hold;

        function new();
            clear_seq();
            nul_hold      = 1'b0;
            mismatches    = 0;
            bytes_noted   = 0;
            chars_checked = 0;
        endfunction

        function void clear_seq();
            seq_len   = '0;
            seq_seen  = '0;
            seq_value = '0;
            seq_min2  = CONT_LO;
        endfunction

        function int unsigned pending();
            return expected_chars.size();
        endfunction

        // BOM, DEL and C0 controls other than tab/LF/CR are dropped
        function bit keep_char(input bit [30:0] cp, output bit [15:0] unit);
            unit = '0;
            if (cp == BOM_POINT || cp == DEL_POINT)
                return 1'b0;
            if (cp < CTRL_END && cp != TAB_POINT && cp != LF_POINT && cp != CR_POINT)
                return 1'b0;
            unit = cp[15:0];
            return 1'b1;
        endfunction

        function bit is_retry(input bit [7:0] b);
            return (b == NUL_BYTE) || (b == TAB_BYTE) || (b == LF_BYTE) ||
                   (b >= SPACE_LO && b <= PUNCT1_HI) ||
                   (b >= PUNCT2_LO && b <= PUNCT2_HI) ||
                   (b >= BRACE_LO && b <= BRACE_HI);
        endfunction

        function bit start_lead(input bit [7:0] b, output bit [15:0] unit);
            unit = '0;
            if (b == NUL_BYTE)
            begin
                nul_hold = 1'b1;
                return 1'b0;
            end
            if (b < ASCII_END)
                return keep_char({23'd0, b}, unit);
            if (b >= LEAD2_LO && b <= LEAD2_HI)
            begin
                seq_len   = 3'd2;
                seq_value = {26'd0, b[4:0]};
                seq_min2  = CONT_LO;
            end
            else if (b >= LEAD3_LO && b <= LEAD3_HI)
            begin
                seq_len   = 3'd3;
                seq_value = {27'd0, b[3:0]};
                seq_min2  = (b == LEAD3_LO) ? MIN2_LEAD3 : CONT_LO;
            end
            else if (b >= LEAD4_LO && b <= LEAD4_HI)
            begin
                seq_len   = 3'd4;
                seq_value = {28'd0, b[2:0]};
                seq_min2  = (b == LEAD4_LO) ? MIN2_LEAD4 : CONT_LO;
            end
            else if (b >= LEAD5_LO && b <= LEAD5_HI)
            begin
                seq_len   = 3'd5;
                seq_value = {29'd0, b[1:0]};
                seq_min2  = (b == LEAD5_LO) ? MIN2_LEAD5 : CONT_LO;
            end
            else if (b >= LEAD6_LO && b <= LEAD6_HI)
            begin
                seq_len   = 3'd6;
                seq_value = {30'd0, b[0]};
                seq_min2  = (b == LEAD6_LO) ? MIN2_LEAD6 : CONT_LO;
            end
            else
                return 1'b0;
            seq_seen = 3'd1;
            return 1'b0;
        endfunction

        function bit decode_byte(input bit [7:0] b, output bit [15:0] unit);
            bit [7:0]  floor_byte;
            bit [30:0] cp;
            unit = '0;
            if (nul_hold)
                return 1'b0;
            if (seq_len == 3'd0)
                return start_lead(b, unit);
            floor_byte = (seq_seen == 3'd1) ? seq_min2 : CONT_LO;
            if (b >= floor_byte && b <= CONT_HI)
            begin
                seq_value = {seq_value[24:0], b[5:0]};
                seq_seen  = seq_seen + 3'd1;
                if (seq_seen >= seq_len)
                begin
                    cp = seq_value;
                    clear_seq();
                    return keep_char(cp, unit);
                end
                return 1'b0;
            end
            if (seq_len == 3'd2)
            begin
                clear_seq();
                if (is_retry(b))
                    return start_lead(b, unit);
                return 1'b0;
            end
            clear_seq();
            return start_lead(b, unit);
        endfunction

        function void note_byte(input text_item_t it);
            bit         have;
            bit [15:0]  unit;
            char_item_t want;
            bytes_noted++;
            have = decode_byte(it.in_byte, unit);
            if (it.last_byte)
            begin
                clear_seq();
                nul_hold = 1'b0;
            end
            if (have || it.last_byte)
            begin
                want.code_unit   = have ? unit : 16'd0;
                want.unit_valid  = have;
                want.end_of_text = it.last_byte;
                expected_chars.insert(expected_chars.size(), want);
            end
        endfunction

        task report(input string msg);
            mismatches++;
            $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task check_char(input char_item_t got);
            char_item_t want;
            chars_checked++;
            if (expected_chars.size() == 0)
            begin
                report($sformatf("char item %h with nothing expected", got));
                return;
            end
            want = expected_chars.pop_front();
            if (got.code_unit !== want.code_unit)
                report($sformatf("code_unit %h, expected %h", got.code_unit, want.code_unit));
            if (got.unit_valid !== want.unit_valid)
                report($sformatf("unit_valid %b, expected %b", got.unit_valid,
                                 want.unit_valid));
            if (got.end_of_text !== want.end_of_text)
                report($sformatf("end_of_text %b, expected %b", got.end_of_text,
                                 want.end_of_text));
        endtask
    endclass

endpackage

[sim/tb_top.sv]
// Top-level bench for utf8_lenient_decoder: directed and random byte texts
// under varied idling, checked against the scoreboard in utf8ld_tb_pkg.
`timescale 1ns / 1ps

module tb_top;
    import utf8ld_pkg::*;
    import utf8ld_tb_pkg::*;

    localparam int QUIET_LIMIT = 3000;   // cycles without any handshake
    localparam int HOLD_OFF    = 300;    // long receiver stall for back-pressure
    localparam int DRAIN_WAIT  = 8;      // drain margin after the input and result registers
    localparam int PHASE_BYTES = 355;

    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       text_valid = 1'b0;
    text_item_t text_item  = '0;
    logic       text_stall;
    logic       char_valid;
    logic       char_stall = 1'b0;
    char_item_t char_item;

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_token     = 0;
    int unsigned hold_taken     = 0;
    int unsigned hold_left      = 0;
    int unsigned quiet_cycles   = 0;
    int unsigned texts_sent     = 0;
    int unsigned bytes_sent     = 0;

    char_scoreboard sb = new();

    always #5 clk = ~clk;

    utf8_lenient_decoder dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_valid (text_valid),
        .text_stall (text_stall),
        .text_item  (text_item),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_item  (char_item)
    );

    // Receiver: random stall per cycle, or a long hold-off when the stimulus
    // asks for one (hold_token bump). Driven on the falling edge.
    always @(negedge clk)
    begin
        if (hold_token != hold_taken)
        begin
            hold_taken <= hold_token;
            hold_left  <= HOLD_OFF;
            char_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left  <= hold_left - 1;
            char_stall <= 1'b1;
        end
        else
            char_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Result side: every accepted char item goes to the scoreboard.
    always @(posedge clk)
    begin
        if (rst_n && char_valid === 1'b1 && char_stall == 1'b0)
            sb.check_char(char_item);
    end

    // Watchdog: any handshake on either side resets the quiet count.
    always @(posedge clk)
    begin
        if (!rst_n || (text_valid && text_stall === 1'b0) ||
            (char_valid === 1'b1 && !char_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("[%0t] watchdog: no progress for %0d cycles", $time, QUIET_LIMIT);
            $display("tb: failure");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Offer one byte item. Called at a falling edge; returns at the falling
    // edge after the item was taken. Valid is only lowered for an idle gap,
    // so back-to-back items keep it high without a glitch.
    task automatic send_byte(input logic [7:0] b, input logic last);
        text_item_t it;
        it.in_byte   = b;
        it.last_byte = last;
        while ($urandom_range(99) < send_idle_pct)
        begin
            text_valid <= 1'b0;
            @(negedge clk);
        end
        text_valid <= 1'b1;
        text_item  <= it;
        do @(posedge clk); while (text_stall !== 1'b0);
        @(negedge clk);
        // noted at the falling edge after the handshake, well ahead of its result
        sb.note_byte(it);
        bytes_sent++;
    endtask

    // random byte in [lo, hi]
    function automatic logic [7:0] rand_byte(input logic [7:0] hi, input logic [7:0] lo);
        return 8'($urandom_range(hi, lo));
    endfunction

    // append one byte to a byte queue
    function automatic void put_byte(ref logic [7:0] q[$], input logic [7:0] v);
        q.insert(q.size(), v);
    endfunction

    // Append one character's worth of bytes to a text. Mostly well-formed
    // shortest-form sequences with random payload; the rest are truncated
    // sequences, bad 2-byte seconds, NULs, BOMs and raw noise.
    function automatic void add_char(ref logic [7:0] q[$]);
        int unsigned pick;
        int unsigned len;
        int unsigned cut;
        logic [7:0]  lead;
        logic [7:0]  min2;
        logic [7:0]  seq[$];
        pick = $urandom_range(99);
        if (pick < 33)
        begin
            put_byte(q, rand_byte(8'h7F, 8'h01));
            return;
        end
        if (pick < 36)
        begin
            // byte-order mark, plain or in a 4-byte form that keeps its low half
            if ($urandom_range(1))
            begin
                put_byte(q, LEAD3_HI);
                put_byte(q, 8'hBB);
                put_byte(q, CONT_HI);
            end
            else
            begin
                put_byte(q, LEAD4_LO);
                put_byte(q, 8'h9F);
                put_byte(q, 8'hBB);
                put_byte(q, CONT_HI);
            end
            return;
        end
        if (pick < 39)
        begin
            put_byte(q, NUL_BYTE);
            return;
        end
        if (pick < 45)
        begin
            put_byte(q, rand_byte(8'hFF, 8'h00));
            return;
        end
        if (pick < 52)
        begin
            // 2-byte lead followed by a retried or a random byte
            put_byte(q, rand_byte(LEAD2_HI, LEAD2_LO));
            case ($urandom_range(2))
                0: put_byte(q, rand_byte(PUNCT1_HI, SPACE_LO));
                1: put_byte(q, rand_byte(BRACE_HI, BRACE_LO));
                default: put_byte(q, rand_byte(8'hFF, 8'h00));
            endcase
            return;
        end

        len = $urandom_range(6, 2);
        case (len)
            2: lead = rand_byte(LEAD2_HI, LEAD2_LO);
            3: lead = rand_byte(LEAD3_HI, LEAD3_LO);
            4: lead = rand_byte(LEAD4_HI, LEAD4_LO);
            5: lead = rand_byte(LEAD5_HI, LEAD5_LO);
            default: lead = rand_byte(LEAD6_HI, LEAD6_LO);
        endcase
        // bias toward the shortest-form leads so the overlong limit is hit
        if ($urandom_range(3) == 0)
        begin
            case (len)
                3: lead = LEAD3_LO;
                4: lead = LEAD4_LO;
                5: lead = LEAD5_LO;
                6: lead = LEAD6_LO;
                default: ;
            endcase
        end
        if (lead == LEAD3_LO)
            min2 = MIN2_LEAD3;
        else if (lead == LEAD4_LO)
            min2 = MIN2_LEAD4;
        else if (lead == LEAD5_LO)
            min2 = MIN2_LEAD5;
        else if (lead == LEAD6_LO)
            min2 = MIN2_LEAD6;
        else
            min2 = CONT_LO;
        put_byte(seq, lead);
        put_byte(seq, rand_byte(CONT_HI, min2));
        repeat (len - 2) put_byte(seq, rand_byte(CONT_HI, CONT_LO));

        if (pick < 86)
        begin
            foreach (seq[i]) put_byte(q, seq[i]);
            return;
        end
        // broken: keep part of the sequence, then a bad or random byte
        cut = $urandom_range(len - 1, 1);
        for (int i = 0; i < cut; i++) put_byte(q, seq[i]);
        case ($urandom_range(2))
            0: put_byte(q, (cut == 1 && min2 != CONT_LO) ?
                           rand_byte(min2 - 8'd1, CONT_LO) : rand_byte(8'hFF, 8'h00));
            1: put_byte(q, rand_byte(8'h7F, 8'h00));
            default: put_byte(q, rand_byte(8'hFF, 8'h00));
        endcase
    endfunction

    // One text: a run of characters, last flag on its final byte.
    task automatic send_text();
        logic [7:0]  bytes_q[$];
        int unsigned n_chars;
        n_chars = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
        repeat (n_chars) add_char(bytes_q);
        foreach (bytes_q[i]) send_byte(bytes_q[i], i == bytes_q.size() - 1);
        texts_sent++;
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed text: ASCII, DEL, a control, minimum 2-byte form, a
        // swallowed and a retried bad second byte, an overlong 3-byte start,
        // a dropped BOM, U+1FEFF kept as FEFF, the largest 6-byte form, a
        // bad lead, and an incomplete tail at the last byte.
        send_byte(8'h41, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(LEAD2_LO, 1'b0);
        send_byte(CONT_LO, 1'b0);
        send_byte(LEAD2_HI, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'hC3, 1'b0);
        send_byte(SPACE_LO, 1'b0);
        send_byte(LEAD3_LO, 1'b0);
        send_byte(8'h9F, 1'b0);
        send_byte(LEAD3_HI, 1'b0);
        send_byte(8'hBB, 1'b0);
        send_byte(CONT_HI, 1'b0);
        send_byte(LEAD4_LO, 1'b0);
        send_byte(8'h9F, 1'b0);
        send_byte(8'hBB, 1'b0);
        send_byte(CONT_HI, 1'b0);
        send_byte(LEAD6_HI, 1'b0);
        repeat (5) send_byte(CONT_HI, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b1);
        // NUL ends the text; bytes after it up to the last are ignored
        send_byte(NUL_BYTE, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'h42, 1'b1);
        texts_sent += 2;

        // Random phases: free-running, sender-idle, receiver-stall, mixed.
        // The first one opens with a long receiver hold-off while the sender
        // keeps pushing, to back the pipe up into text_stall.
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
                1: begin send_idle_pct = 80; recv_stall_pct <= 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct <= 80; end
                default: begin send_idle_pct = 31; recv_stall_pct <= 31; end
            endcase
            if (ph == 0)
                hold_token <= hold_token + 1;
            while (bytes_sent < 30 + PHASE_BYTES * (ph + 1))
                send_text();
        end

        text_valid     <= 1'b0;
        recv_stall_pct <= 0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("covered %0d texts, %0d byte items, %0d char items checked",
                 texts_sent, bytes_sent, sb.chars_checked);
        $display("idling phases: none, sender, receiver, both; %0d mismatches",
                 sb.mismatches);
        if (sb.mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
